### design/assert_macros.svh
// Assertion macros for the design files, used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define BEG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked property that also holds across reset.
`define BEG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define BEG_ASSERT(name, clk, rst, prop)
`define BEG_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### design/beg_pkg.sv
`timescale 1ns / 1ps
package beg_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int FRAC_BITS = 16;
  localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;
  localparam int QUARTER = ROM_SIZE / 4;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_SWING = 2'd1,
    CFG_RATE  = 2'd2,
    CFG_PHASE = 2'd3
  } cfg_idx_t;

  // Envelope modes.
  typedef enum logic [1:0] {
    MODE_CONST   = 2'd0,
    MODE_FLICKER = 2'd1,
    MODE_PULSE   = 2'd2,
    MODE_STROBE  = 2'd3
  } mode_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_HMIX,
    OP_HMUL,
    OP_HDIV,
    OP_ROMRD,
    OP_ROMUSE,
    OP_STBMUL,
    OP_STBFIX,
    OP_SM1,
    OP_SM2,
    OP_BLEND1,
    OP_BLEND2,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic second;
    logic cosine;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  mid;
  } status_t;

  typedef logic [16:0] qtab_t [0:QUARTER];

  // Quarter-wave sine in Q16 from an 11th-order Taylor series in Q30.
  function automatic logic [16:0] quarter_sine(int unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    begin
      x = (longint'(j) * 2 * PI_Q30) / ROM_SIZE;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 5; k++) begin
        term = (term * x2) >> 30;
        case (k)
          1: term = term / 6;
          2: term = term / 20;
          3: term = term / 42;
          4: term = term / 72;
          default: term = term / 110;
        endcase
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      sum = (sum + 8192) >>> 14;
      if (sum > 65536) sum = 65536;
      return 17'(sum);
    end
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    begin
      for (int i = 0; i <= QUARTER; i++) begin
        tab[i] = quarter_sine(i);
      end
      return tab;
    end
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

### design/brightness_envelope_generator.sv
`timescale 1ns / 1ps
// The controller sequence sets the path from input beat to result: constant mode
// goes straight to the output wait, and flicker mode takes the longest path.
// Throughput: one tick at a time; the next beat is taken once the result is
// in the output register, which holds it until the consumer takes it.
// One shared multiplier does every product, one per cycle.
// Synchronous reset clears the clock, the config registers and handshake state.
module brightness_envelope_generator
  import beg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] tick_seconds
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [16:0] brightness_factor, [23:17] zero
);

  cmd_t        cmd;
  status_t     status;
  logic [16:0] factor;

  assign cfg_ready = 1'b1;
  assign m_tdata = {7'd0, factor};

  beg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  beg_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_idx_t'(cfg_index)),
    .cfg_data         (cfg_data),
    .tick_seconds     (s_tdata),
    .cmd              (cmd),
    .status           (status),
    .brightness_factor(factor)
  );

endmodule

### design/beg_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module beg_ctrl
  import beg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SCALE, S_HMIX0, S_HMUL0, S_HDIV0, S_HMIX1, S_HMUL1, S_HDIV1,
    S_ROMRD, S_ROMUSE, S_STBMUL, S_STBFIX, S_SM1, S_SM2, S_BLEND1, S_BLEND2,
    S_OUTW
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUTW) && (!out_valid || out_ready);

  // Command decode and next state.
  always_comb begin
    cmd = '{op: OP_NONE, second: 1'b0, cosine: 1'b0};
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = (status.mode == MODE_CONST) ? S_OUTW : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = (status.mode == MODE_FLICKER) ? S_HMIX0 : S_ROMRD;
      end
      S_HMIX0: begin
        cmd.op = OP_HMIX;
        state_next = S_HMUL0;
      end
      S_HMUL0: begin
        cmd.op = OP_HMUL;
        state_next = S_HDIV0;
      end
      S_HDIV0: begin
        cmd.op = OP_HDIV;
        state_next = S_HMIX1;
      end
      S_HMIX1: begin
        cmd.op = OP_HMIX;
        cmd.second = 1'b1;
        state_next = S_HMUL1;
      end
      S_HMUL1: begin
        cmd.op = OP_HMUL;
        state_next = S_HDIV1;
      end
      S_HDIV1: begin
        cmd.op = OP_HDIV;
        cmd.second = 1'b1;
        state_next = S_SM1;
      end
      S_ROMRD: begin
        cmd.op = OP_ROMRD;
        cmd.cosine = (status.mode == MODE_STROBE);
        state_next = S_ROMUSE;
      end
      S_ROMUSE: begin
        cmd.op = OP_ROMUSE;
        state_next = (status.mode == MODE_STROBE && status.mid) ? S_STBMUL : S_OUTW;
      end
      S_STBMUL: begin
        cmd.op = OP_STBMUL;
        state_next = S_STBFIX;
      end
      S_STBFIX: begin
        cmd.op = OP_STBFIX;
        state_next = S_SM1;
      end
      S_SM1: begin
        cmd.op = OP_SM1;
        state_next = S_SM2;
      end
      S_SM2: begin
        cmd.op = OP_SM2;
        state_next = (status.mode == MODE_FLICKER) ? S_BLEND1 : S_OUTW;
      end
      S_BLEND1: begin
        cmd.op = OP_BLEND1;
        state_next = S_BLEND2;
      end
      S_BLEND2: begin
        cmd.op = OP_BLEND2;
        state_next = S_OUTW;
      end
      S_OUTW: begin
        if (load_out) begin
          cmd.op = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `BEG_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `BEG_ASSERT(a_no_overwrite, clk, rst, (cmd.op == OP_OUT) |-> (!out_valid || out_ready))
  `BEG_ASSERT(a_valid_from_out, clk, rst, $rose(out_valid) |-> $past(cmd.op == OP_OUT))
  `BEG_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid))

endmodule

### design/beg_datapath.sv
`timescale 1ns / 1ps
module beg_datapath
  import beg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [15:0] tick_seconds,
  input  cmd_t        cmd,
  output status_t     status,
  output logic [16:0] brightness_factor
);

  localparam logic signed [17:0] EDGE_POS = 18'sd3277;
  localparam logic signed [17:0] EDGE_NEG = -18'sd3277;
  localparam int AW = SINE_TABLE_BITS - 1;

  mode_t       mode;
  logic [16:0] swing;
  logic [23:0] rate;
  logic [31:0] phase;
  logic [31:0] elapsed;
  logic [31:0] t_q;
  logic [23:0] xi;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [31:0] u;
  logic [23:0] h24;
  logic [16:0] ha;
  logic [16:0] hb;
  logic [16:0] romq;
  logic        neg_r;
  logic [12:0] n_r;
  logic [15:0] q0_r;
  logic [16:0] smt;
  logic [33:0] t2;
  logic [16:0] s;
  logic [33:0] acc;
  logic [16:0] shape;

  logic [33:0] mul_a;
  logic [31:0] mul_b;
  logic [65:0] prod;
  logic [16:0] amp;
  logic [31:0] elapsed_sum;
  logic [31:0] p32;
  logic [31:0] hsrc;
  logic [31:0] m1;
  logic [31:0] m2;
  logic [31:0] m3;
  logic [31:0] hv;
  logic [40:0] hn;
  logic [24:0] hr;
  logic [16:0] hq;
  logic [1:0]  quad;
  logic [AW-2:0] jlo;
  logic [AW-1:0] raddr;
  logic signed [17:0] sinv;
  logic signed [18:0] psum;
  logic [29:0] sr;
  logic [34:0] bsum;
  logic [34:0] osum;
  logic [52:0] ssum;

  assign amp = (swing > 17'd65536) ? 17'd65536 : swing;
  assign elapsed_sum = elapsed + 32'(tick_seconds);
  assign status.mode = mode;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SCALE:  begin mul_a = 34'(t_q);   mul_b = 32'(rate); end
      OP_HMUL:   begin mul_a = 34'(u);     mul_b = 32'h27d4eb2d; end
      OP_STBMUL: begin mul_a = 34'(n_r);   mul_b = 32'd655320; end
      OP_STBFIX: begin mul_a = 34'(q0_r);  mul_b = 32'd6554; end
      OP_SM1:    begin mul_a = 34'(smt);   mul_b = 32'(smt); end
      OP_SM2:    begin mul_a = t2;         mul_b = 32'd196608 - 32'({smt, 1'b0}); end
      OP_BLEND1: begin mul_a = 34'(ha);    mul_b = 32'd65536 - 32'(s); end
      OP_BLEND2: begin mul_a = 34'(hb);    mul_b = 32'(s); end
      OP_OUT:    begin mul_a = 34'(amp);   mul_b = 32'd65536 - 32'(shape); end
      default: ;
    endcase
  end
  assign prod = 66'(mul_a) * 66'(mul_b);

  // Fraction of the scaled time, truncated to the fraction width.
  assign p32 = {prod[31 -: FRAC_BITS], {(32 - FRAC_BITS){1'b0}}};

  // Hash mixing before and after the multiply.
  assign hsrc = cmd.second ? 32'(xi) + 32'd1 : 32'(xi);
  assign m1 = (hsrc ^ 32'd61) ^ (hsrc >> 16);
  assign m2 = m1 + (m1 << 3);
  assign m3 = m2 ^ (m2 >> 4);
  assign hv = prod[31:0] ^ (prod[31:0] >> 15);

  // Normalize the 24-bit hash: divide by 2^24-1 with one correction step.
  assign hn = {1'b0, h24, 16'd0} + 41'd8388607;
  assign hr = 25'(hn[23:0]) + 25'(hn[40:24]);
  assign hq = hn[40:24] + 17'(hr >= 25'd16777215);

  // Quarter-wave folding of the table index.
  assign quad = idx[SINE_TABLE_BITS-1 -: 2] + {1'b0, cmd.cosine};
  assign jlo = idx[SINE_TABLE_BITS-3:0];
  assign raddr = quad[0] ? AW'(QUARTER) - AW'(jlo) : AW'(jlo);
  assign sinv = neg_r ? -$signed({1'b0, romq}) : $signed({1'b0, romq});
  assign psum = 19'sd65536 + 19'(sinv);
  assign status.mid = (sinv > EDGE_NEG) && (sinv < EDGE_POS);

  assign sr = 30'({n_r, 16'd0}) - prod[29:0];
  assign ssum = prod[52:0] + 53'h80000000;
  assign bsum = 35'(acc) + 35'(prod[33:0]) + 35'd32768;
  assign osum = 35'(prod[33:0]) + 35'd32768;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CONST;
      swing <= '0;
      rate <= 24'd65536;
      phase <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode <= mode_t'(cfg_data[1:0]);
        CFG_SWING: swing <= cfg_data[16:0];
        CFG_RATE:  rate <= cfg_data[23:0];
        CFG_PHASE: phase <= cfg_data;
        default: ;
      endcase
    end
  end

  // Running clock.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (cmd.op == OP_LOAD) begin
      elapsed <= elapsed_sum;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t_q <= elapsed_sum + phase;
        shape <= 17'd65536;
      end
      OP_SCALE: begin
        xi <= prod[55:32];
        smt <= 17'(p32[31:16]);
        idx <= p32[31 -: SINE_TABLE_BITS];
      end
      OP_HMIX: u <= m3;
      OP_HMUL: h24 <= hv[23:0];
      OP_HDIV: begin
        if (cmd.second) begin
          hb <= hq;
        end else begin
          ha <= hq;
        end
      end
      OP_ROMRD: begin
        romq <= QTAB[raddr];
        neg_r <= quad[1];
      end
      OP_ROMUSE: begin
        if (mode == MODE_PULSE) begin
          shape <= psum[17:1];
        end else if (sinv <= EDGE_NEG) begin
          shape <= '0;
        end else if (sinv >= EDGE_POS) begin
          shape <= 17'd65536;
        end else begin
          n_r <= 13'(sinv + EDGE_POS);
        end
      end
      OP_STBMUL: q0_r <= prod[31:16];
      OP_STBFIX: smt <= 17'(q0_r) + 17'(sr >= 30'd6554);
      OP_SM1: t2 <= prod[33:0];
      OP_SM2: begin
        s <= ssum[48:32];
        shape <= ssum[48:32];
      end
      OP_BLEND1: acc <= prod[33:0];
      OP_BLEND2: shape <= bsum[32:16];
      OP_OUT: brightness_factor <= 17'd65536 - osum[32:16];
      default: ;
    endcase
  end

endmodule

### test/brightness_envelope_generator_tb.sv
`timescale 1ns / 1ps
module brightness_envelope_generator_tb;
  import beg_pkg::*;

  localparam int ONE = 65536;
  localparam int EDGE = 3277;
  localparam longint unsigned PI_Q30_TB = 64'd3373259426;
  localparam int TBL = 1024;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  // Predictor state and register copies.
  logic [31:0] clock_q16;
  mode_t       mode_r;
  logic [16:0] swing_r;
  logic [23:0] rate_r;
  logic [31:0] phase_r;
  int          sine_tab [TBL];

  logic [16:0] pending_factors [$];
  int          error_count = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  brightness_envelope_generator u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Quarter-wave sine in Q16, Taylor series evaluated in Q30.
  function automatic int taylor_sine(int unsigned j);
    longint unsigned x, x2, term;
    longint acc;
    x = (longint'(j) * 2 * PI_Q30_TB) / TBL;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 8192) / 16384;
    if (acc > 65536) acc = 65536;
    return int'(acc);
  endfunction

  function automatic longint unsigned smoothstep_q16(longint unsigned t);
    if (t > ONE) t = ONE;
    return (t * t * (196608 - 2 * t) + 64'd2147483648) >> 32;
  endfunction

  function automatic longint unsigned noise_q16(logic [31:0] u);
    longint unsigned h;
    u = (u ^ 32'd61) ^ (u >> 16);
    u = u + (u << 3);
    u = u ^ (u >> 4);
    u = u * 32'h27d4eb2d;
    u = u ^ (u >> 15);
    h = u & 32'h00FFFFFF;
    return (h * 65536 + 8388607) / 16777215;
  endfunction

  // Advances the clock by one tick and returns the expected factor.
  function automatic logic [16:0] next_brightness(logic [15:0] tick);
    logic [31:0] t, xi;
    longint unsigned prod, xq, p, a, b, s, shape, amp;
    int idx, c;
    clock_q16 = clock_q16 + tick;
    t = clock_q16 + phase_r;
    prod = longint'(t) * longint'(rate_r);
    xq = prod >> 16;
    xi = 32'(xq >> 16);
    p = (xq & 64'hFFFF) << 16;
    idx = int'((p >> 22) & (TBL - 1));
    shape = ONE;
    case (mode_r)
      MODE_FLICKER: begin
        a = noise_q16(xi);
        b = noise_q16(xi + 32'd1);
        s = smoothstep_q16(p >> 16);
        shape = (a * (ONE - s) + b * s + 32768) >> 16;
      end
      MODE_PULSE: shape = longint'(65536 + sine_tab[idx]) >> 1;
      MODE_STROBE: begin
        c = sine_tab[(idx + TBL / 4) & (TBL - 1)];
        if (c <= -EDGE) shape = 0;
        else if (c >= EDGE) shape = ONE;
        else shape = smoothstep_q16((longint'(c + EDGE) * 65536) / (2 * EDGE));
      end
      default: ;
    endcase
    amp = (swing_r > ONE) ? ONE : swing_r;
    if (mode_r == MODE_CONST) return 17'(ONE);
    return 17'(ONE - ((amp * (ONE - shape) + 32768) >> 16));
  endfunction

  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Sends one tick beat; valid stays high into the next beat when there is no gap.
  task automatic send_tick(logic [15:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= tick;
    do @(posedge clk); while (!s_tready);
    pending_factors = {pending_factors, next_brightness(tick)};
  endtask

  task automatic drain();
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register writes only happen with the block idle.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODE:  mode_r = mode_t'(val[1:0]);
      CFG_SWING: swing_r = val[16:0];
      CFG_RATE:  rate_r = val[23:0];
      default:   phase_r = val;
    endcase
  endtask

  task automatic setup(mode_t m, logic [31:0] sw, logic [31:0] rt, logic [31:0] ph);
    write_reg(CFG_MODE, 32'(m));
    write_reg(CFG_SWING, sw);
    write_reg(CFG_RATE, rt);
    write_reg(CFG_PHASE, ph);
  endtask

  // Constant mode ignores depth, even at full swing.
  task automatic test_constant();
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    setup(MODE_CONST, 32'd65536, 32'hFFFFFF, 32'hFFFF0000);
    send_tick(16'hFFFF);
    send_tick(16'h5A5A);
  endtask

  // Flicker at the top of the rate range and at zero rate, with the phase sum wrapping.
  task automatic test_flicker();
    setup(MODE_FLICKER, 32'd65536, 32'hFFFFFF, 32'hFFFFFFFF);
    send_tick(16'h0000);
    send_tick(16'h0001);
    send_tick(16'hFFFF);
    send_tick(16'h8000);
    write_reg(CFG_RATE, 32'd0);
    send_tick(16'h1234);
  endtask

  // Pulse with a depth above one, which must be clamped, then with zero depth.
  task automatic test_pulse();
    setup(MODE_PULSE, 32'h1FFFF, 32'd65536, 32'd0);
    repeat (4) send_tick(16'h4000);
    write_reg(CFG_SWING, 32'd0);
    send_tick(16'h3333);
  endtask

  // Strobe at unit rate, stepping with small ticks and then one large tick.
  task automatic test_strobe();
    setup(MODE_STROBE, 32'd65536, 32'd65536, 32'h00003F00);
    repeat (6) send_tick(16'h0040);
    send_tick(16'hAAAA);
  endtask

  task automatic test_random();
    logic [15:0] tick;
    logic [31:0] sw, rt, ph;
    for (int blk = 0; blk < 14; blk++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: sw = 32'd65536;
        1: sw = 32'd0;
        2: sw = $urandom_range(65537, 131071);
        default: sw = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 3))
        0: rt = 32'hFFFFFF;
        1: rt = 32'd0;
        default: rt = $urandom_range(0, 24'hFFFFFF);
      endcase
      ph = ($urandom_range(0, 3) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 65535) : $urandom;
      setup(mode_t'($urandom_range(0, 3)), sw, rt, ph);
      repeat (45) begin
        case ($urandom_range(0, 9))
          0: tick = 16'h0000;
          1: tick = 16'hFFFF;
          2: tick = 16'($urandom_range(0, 255));
          default: tick = 16'($urandom);
        endcase
        send_tick(tick);
      end
    end
  endtask

  // Consumer side: short random stalls with an occasional long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 49) == 0) begin
      stall_left <= $urandom_range(5, 40);
      m_tready <= 1'b0;
    end else begin
      m_tready <= !idle_on || ($urandom_range(0, 3) != 0);
    end
  end

  // Each result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_factors.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[16:0], 17'd0);
      end else begin
        if (m_tdata[16:0] !== pending_factors[0])
          report_mismatch("brightness_factor", m_tdata[16:0], pending_factors[0]);
        void'(pending_factors.pop_front());
      end
    end
  end

  initial begin
    for (int i = 0; i < TBL; i++) begin
      int q, j, v;
      q = i / (TBL / 4);
      j = i % (TBL / 4);
      v = (q % 2 == 1) ? taylor_sine(TBL / 4 - j) : taylor_sine(j);
      sine_tab[i] = (q >= 2) ? -v : v;
    end
    clock_q16 = '0;
    mode_r = MODE_CONST;
    swing_r = '0;
    rate_r = 24'd65536;
    phase_r = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_constant();
    test_flicker();
    test_pulse();
    test_strobe();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("brightness_envelope_generator_tb: clean");
    end else begin
      $display("brightness_envelope_generator_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("brightness_envelope_generator_tb: errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/beg_pkg.sv
design/beg_ctrl.sv
design/beg_datapath.sv
design/brightness_envelope_generator.sv
test/brightness_envelope_generator_tb.sv
